FILE: hdl/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Event codes, flag bytes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam logic [7:0] START_FLAG = 8'h5b;
    localparam logic [7:0] END_FLAG   = 8'h5d;
    localparam logic [7:0] ESC_A      = 8'h5a;
    localparam logic [7:0] ESC_E      = 8'h5e;
    localparam logic [7:0] ESC_ONE    = 8'h01;
    localparam logic [7:0] ESC_TWO    = 8'h02;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hffff;

    localparam logic [31:0] HDR_END   = 32'd24;
    localparam logic [31:0] MIN_LEN   = 32'd26;

    localparam logic [31:0] MOD_RESET = 32'h0000_fffa;
    localparam logic [31:0] MUL_RESET = 32'h0000_fffb;
    localparam logic [31:0] INC_RESET = 32'h0000_fffc;

    localparam logic [1:0] REG_MODULUS    = 2'd0;
    localparam logic [1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [1:0] REG_INCREMENT  = 2'd2;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PEND_A = 2'd1;
    localparam logic [1:0] ESC_PEND_E = 2'd2;

    localparam logic [2:0] EV_BODY     = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_BAD_ESC  = 3'd2;
    localparam logic [2:0] EV_BAD_LEN  = 3'd3;
    localparam logic [2:0] EV_CRC_ERR  = 3'd4;
    localparam logic [2:0] EV_BAD_END  = 3'd5;

    localparam logic [4:0] MOD_LAST = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_MUL_LO,
        S_MUL_HI,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mod_step;
        logic mul_lo;
        logic mul_hi;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_key;
        logic has_result;
        logic mod_last;
        logic out_free;
    } t_status;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/efd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_ctrl: sequencing state machine
// Evaluates each byte; keyed ones get key reduction and product; results emit.
// ----------------------------------------------------------------------------
module efd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  efd_pkg::t_status i_status,
    output efd_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    efd_pkg::t_state r_state;
    efd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            efd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = efd_pkg::S_EVAL;
            end
            efd_pkg::S_EVAL: begin
                if (i_status.need_key) n_state = efd_pkg::S_MOD;
                else if (i_status.has_result) n_state = efd_pkg::S_EMIT;
                else n_state = efd_pkg::S_IDLE;
            end
            efd_pkg::S_MOD: begin
                if (i_status.mod_last) n_state = efd_pkg::S_MUL_LO;
            end
            efd_pkg::S_MUL_LO: n_state = efd_pkg::S_MUL_HI;
            efd_pkg::S_MUL_HI: n_state = efd_pkg::S_EMIT;
            efd_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = efd_pkg::S_IDLE;
            end
            default: n_state = efd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        case (r_state)
            efd_pkg::S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            efd_pkg::S_EVAL:   o_cmd.eval     = 1'b1;
            efd_pkg::S_MOD:    o_cmd.mod_step = 1'b1;
            efd_pkg::S_MUL_LO: o_cmd.mul_lo   = 1'b1;
            efd_pkg::S_MUL_HI: o_cmd.mul_hi   = 1'b1;
            efd_pkg::S_EMIT:   o_cmd.emit     = i_status.out_free;
            default:           o_busy         = 1'b1;
        endcase
    end

endmodule

FILE: hdl/efd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_datapath: frame state, header fields, CRC, key stream and result beat
// Evaluates one byte per command, reduces the key serially, holds the output.
// ----------------------------------------------------------------------------
module efd_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  efd_pkg::t_cmd    i_cmd,
    output efd_pkg::t_status o_status,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_body_byte,
    output logic [31:0]      o_frame_length,
    output logic [31:0]      o_serial_number,
    output logic [15:0]      o_message_id,
    output logic [31:0]      o_center_code,
    output logic [23:0]      o_protocol_version,
    output logic             o_encrypted,
    output logic [31:0]      o_key_seed,
    output logic [15:0]      o_crc_received,
    output logic [15:0]      o_crc_computed
);

    logic [31:0] r_modulus, r_mult, r_inc;
    logic [7:0]  r_byte;
    logic [31:0] r_pos, n_pos;
    logic [1:0]  r_esc, n_esc;
    logic [31:0] r_len, n_len;
    logic [31:0] r_serial, n_serial;
    logic [15:0] r_id, n_id;
    logic [31:0] r_center, n_center;
    logic [23:0] r_version, n_version;
    logic        r_enc, n_enc;
    logic [31:0] r_key, n_key;
    logic [31:0] r_run, n_run;
    logic [15:0] r_crcrx, n_crcrx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_ch, n_ch;
    logic [2:0]  r_ev, n_ev;
    logic        r_restart, n_restart;
    logic        has_result, need_key, stop;
    logic [31:0] p1, lm2, kfix;

    logic [31:0] r_dvd, r_rem, r_prod;
    logic [4:0]  r_cnt;
    logic [32:0] rem_sh;
    logic [47:0] prod_lo, prod_hi;

    logic        r_ov;
    logic        out_free;

    assign out_free = !r_ov || !i_stall;

    always_comb begin
        n_pos = r_pos;   n_esc = r_esc;   n_len = r_len;   n_serial = r_serial;
        n_id = r_id;     n_center = r_center; n_version = r_version; n_enc = r_enc;
        n_key = r_key;   n_run = r_run;   n_crcrx = r_crcrx; n_crc = r_crc;
        n_ch = r_byte;   n_ev = efd_pkg::EV_BODY; n_restart = 1'b0;
        has_result = 1'b0; need_key = 1'b0; stop = 1'b0;
        p1 = r_pos + 32'd1;
        lm2 = r_len - 32'd2;
        kfix = r_key;

        if (r_pos == '0) begin
            if (r_byte == efd_pkg::START_FLAG) begin
                n_pos = 32'd1; n_esc = efd_pkg::ESC_NONE; n_len = '1;
                n_crcrx = '0;  n_crc = efd_pkg::CRC_INIT;
            end
        end else begin
            n_esc = efd_pkg::ESC_NONE;
            if (r_esc == efd_pkg::ESC_PEND_A) begin
                if (r_byte == efd_pkg::ESC_ONE) n_ch = efd_pkg::START_FLAG;
                else if (r_byte == efd_pkg::ESC_TWO) n_ch = efd_pkg::ESC_A;
                else begin
                    stop = 1'b1; has_result = 1'b1; n_ev = efd_pkg::EV_BAD_ESC;
                end
            end else if (r_esc == efd_pkg::ESC_PEND_E) begin
                if (r_byte == efd_pkg::ESC_ONE) n_ch = efd_pkg::END_FLAG;
                else if (r_byte == efd_pkg::ESC_TWO) n_ch = efd_pkg::ESC_E;
                else begin
                    stop = 1'b1; has_result = 1'b1; n_ev = efd_pkg::EV_BAD_ESC;
                end
            end else if (r_byte == efd_pkg::ESC_A) begin
                n_esc = efd_pkg::ESC_PEND_A; stop = 1'b1;
            end else if (r_byte == efd_pkg::ESC_E) begin
                n_esc = efd_pkg::ESC_PEND_E; stop = 1'b1;
            end

            if (!stop) begin
                n_pos = p1;
                if (p1 < lm2) n_crc = efd_pkg::crc_update(r_crc, n_ch);
                if (p1 < efd_pkg::HDR_END) begin
                    case (p1[4:0])
                        5'd2:  n_len      = {n_ch, 24'h0};
                        5'd3:  n_len      = {r_len[31:24], n_ch, 16'h0};
                        5'd4:  n_len      = {r_len[31:16], n_ch, 8'h0};
                        5'd5:  n_len      = {r_len[31:8], n_ch};
                        5'd6:  n_serial   = {n_ch, 24'h0};
                        5'd7:  n_serial   = {r_serial[31:24], n_ch, 16'h0};
                        5'd8:  n_serial   = {r_serial[31:16], n_ch, 8'h0};
                        5'd9:  n_serial   = {r_serial[31:8], n_ch};
                        5'd10: n_id       = {n_ch, 8'h0};
                        5'd11: n_id       = {r_id[15:8], n_ch};
                        5'd12: n_center   = {n_ch, 24'h0};
                        5'd13: n_center   = {r_center[31:24], n_ch, 16'h0};
                        5'd14: n_center   = {r_center[31:16], n_ch, 8'h0};
                        5'd15: n_center   = {r_center[31:8], n_ch};
                        5'd16: n_version  = {n_ch, r_version[15:0]};
                        5'd17: n_version  = {r_version[23:16], n_ch, r_version[7:0]};
                        5'd18: n_version  = {r_version[23:8], n_ch};
                        5'd19: n_enc      = (n_ch != 8'h00);
                        5'd20: n_key      = {n_ch, 24'h0};
                        5'd21: n_key      = {r_key[31:24], n_ch, 16'h0};
                        5'd22: n_key      = {r_key[31:16], n_ch, 8'h0};
                        5'd23: n_key      = {r_key[31:8], n_ch};
                        default: n_key    = r_key;
                    endcase
                end else begin
                    if (p1 == efd_pkg::HDR_END) begin
                        if (r_len < efd_pkg::MIN_LEN) begin
                            stop = 1'b1; has_result = 1'b1; n_ev = efd_pkg::EV_BAD_LEN;
                        end else begin
                            kfix  = (r_key == '0) ? 32'd1 : r_key;
                            n_key = kfix;
                            n_run = kfix;
                        end
                    end
                    if (!stop) begin
                        if (p1 == lm2) begin
                            n_crcrx = {n_ch, 8'h00};
                        end else if (p1 == r_len - 32'd1) begin
                            n_crcrx = {r_crcrx[15:8], n_ch};
                            if (n_crcrx != n_crc) begin
                                stop = 1'b1; has_result = 1'b1;
                                n_ev = efd_pkg::EV_CRC_ERR;
                            end
                        end else if (p1 == r_len) begin
                            has_result = 1'b1;
                            if (n_ch != efd_pkg::END_FLAG) begin
                                stop = 1'b1; n_ev = efd_pkg::EV_BAD_END;
                            end else begin
                                n_ev = efd_pkg::EV_OK; n_pos = '0;
                            end
                        end else if (r_enc) begin
                            need_key = 1'b1;
                        end else begin
                            has_result = 1'b1;
                        end
                    end
                end
            end

            // failure: drop back to hunting, recheck the byte for a start flag
            if (stop && has_result) begin
                n_pos     = '0;
                n_esc     = efd_pkg::ESC_NONE;
                n_restart = (r_byte == efd_pkg::START_FLAG);
            end
        end
    end

    assign rem_sh  = {r_rem, r_dvd[31]};
    assign prod_lo = r_mult * r_rem[15:0];
    assign prod_hi = r_mult * r_rem[31:16];

    assign o_status.need_key   = need_key;
    assign o_status.has_result = has_result;
    assign o_status.mod_last   = (r_cnt == efd_pkg::MOD_LAST);
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= efd_pkg::MOD_RESET;
            r_mult    <= efd_pkg::MUL_RESET;
            r_inc     <= efd_pkg::INC_RESET;
            r_pos     <= '0;
            r_esc     <= efd_pkg::ESC_NONE;
            r_len     <= '1;
            r_serial  <= '0;
            r_id      <= '0;
            r_center  <= '0;
            r_version <= '0;
            r_enc     <= 1'b0;
            r_key     <= '0;
            r_run     <= '0;
            r_crcrx   <= '0;
            r_crc     <= efd_pkg::CRC_INIT;
            r_restart <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    efd_pkg::REG_MODULUS:    r_modulus <= i_cfg_data;
                    efd_pkg::REG_MULTIPLIER: r_mult    <= i_cfg_data;
                    efd_pkg::REG_INCREMENT:  r_inc     <= i_cfg_data;
                    default:                 r_inc     <= r_inc;
                endcase
            end
            if (i_cmd.eval) begin
                r_pos <= n_pos;     r_esc <= n_esc;       r_len <= n_len;
                r_serial <= n_serial; r_id <= n_id;       r_center <= n_center;
                r_version <= n_version; r_enc <= n_enc;   r_key <= n_key;
                r_run <= n_run;     r_crcrx <= n_crcrx;   r_crc <= n_crc;
                r_restart <= n_restart;
            end
            if (i_cmd.mul_hi) begin
                r_run <= r_prod + {prod_hi[15:0], 16'h0000} + r_inc;
            end
            if (o_valid && !i_stall) r_ov <= 1'b0;
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                if (r_restart) begin
                    r_pos   <= 32'd1;
                    r_esc   <= efd_pkg::ESC_NONE;
                    r_len   <= '1;
                    r_crcrx <= '0;
                    r_crc   <= efd_pkg::CRC_INIT;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_byte <= i_rx_byte;
        if (i_cmd.eval) begin
            r_ch  <= n_ch;
            r_ev  <= n_ev;
            r_dvd <= n_run;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mod_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
            if (rem_sh >= {1'b0, r_modulus}) begin
                r_rem <= 32'(rem_sh - {1'b0, r_modulus});
            end else begin
                r_rem <= rem_sh[31:0];
            end
        end
        if (i_cmd.mul_lo) r_prod <= prod_lo[31:0];
        if (i_cmd.emit) begin
            o_event_res        <= r_ev;
            o_body_byte        <= (r_ev != efd_pkg::EV_BODY) ? 8'h00 :
                                  (r_enc ? (r_ch ^ r_run[27:20]) : r_ch);
            o_frame_length     <= r_len;
            o_serial_number    <= r_serial;
            o_message_id       <= r_id;
            o_center_code      <= r_center;
            o_protocol_version <= r_version;
            o_encrypted        <= r_enc;
            o_key_seed         <= r_key;
            o_crc_received     <= r_crcrx;
            o_crc_computed     <= r_crc;
        end
    end

    assign o_valid = r_ov;

endmodule

FILE: hdl/escaped_frame_deframer_crc_decrypt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc_decrypt_top: escaped link deframer with CRC check
// Hunts the start flag, unescapes, unpacks the header, checks CRC and end flag,
// and emits decrypted body bytes and frame status beats.
// ----------------------------------------------------------------------------
// Sequence: a byte that gives no beat is accepted and evaluated; a plain
//   body byte or status beat is then emitted to the output register.
// An encrypted body byte also passes through the bit-serial key modulo and
//   the split 32x16 key product (low half, then high half) before the emit.
// No new byte is taken before the last is done: the input stalls while busy and
//   while a finished beat waits in a full output register.
// Reset (synchronous, active low) restores the key registers to their
//   defaults and returns the deframer to hunting for a start flag.
module escaped_frame_deframer_crc_decrypt_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // result beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_frame_length,
    output logic [31:0] o_serial_number,
    output logic [15:0] o_message_id,
    output logic [31:0] o_center_code,
    output logic [23:0] o_protocol_version,
    output logic        o_encrypted,
    output logic [31:0] o_key_seed,
    output logic [15:0] o_crc_received,
    output logic [15:0] o_crc_computed
);

    efd_pkg::t_cmd    cmd;
    efd_pkg::t_status status;
    logic             busy;

    // hold the input off whenever the sequencer is not idle
    assign o_stall = busy;

    efd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // frame state, key stream unit and the output register
    efd_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_rx_byte          (i_rx_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_event_res        (o_event_res),
        .o_body_byte        (o_body_byte),
        .o_frame_length     (o_frame_length),
        .o_serial_number    (o_serial_number),
        .o_message_id       (o_message_id),
        .o_center_code      (o_center_code),
        .o_protocol_version (o_protocol_version),
        .o_encrypted        (o_encrypted),
        .o_key_seed         (o_key_seed),
        .o_crc_received     (o_crc_received),
        .o_crc_computed     (o_crc_computed)
    );

endmodule

FILE: hdl/efd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_checker: port-level checks of the deframer
// Watches beat ordering and result coding at the top-level ports.
// ----------------------------------------------------------------------------
module efd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_event_res,
    input logic [7:0] o_body_byte
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) && $stable(o_body_byte))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken twice in successive cycles");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_res <= efd_pkg::EV_BAD_END)
        else $error("event code out of range");

    a_body_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != efd_pkg::EV_BODY |-> o_body_byte == 8'h00)
        else $error("status beat carries a body byte");

endmodule

bind escaped_frame_deframer_crc_decrypt_top efd_checker u_efd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_event_res (o_event_res),
    .o_body_byte (o_body_byte)
);
